@@ design/spma_pkg.sv @@
// Shared types, request codes and constants for the sparse polynomial multiply/add unit.
package spma_pkg;

  localparam int MAX_TERMS_DEF     = 8;
  localparam int PRODUCT_TERMS_DEF = 64;
  localparam int OUT_LIMIT         = 64;
  localparam int OUT_W             = $clog2(OUT_LIMIT + 1);

  localparam logic signed [35:0] COEF_MAX = {1'b0, {35{1'b1}}};
  localparam logic signed [35:0] COEF_MIN = {1'b1, {35{1'b0}}};

  // request codes
  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_LOAD_A = 3'd1,
    REQ_LOAD_B = 3'd2,
    REQ_PROD   = 3'd3,
    REQ_SUM    = 3'd4
  } req_t;

  localparam logic KIND_PROD = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] term_coef_in;
    logic [14:0]        term_expon_in;
  } in_beat_t;

  typedef struct packed {
    logic               list_kind;
    logic signed [35:0] term_coef;
    logic [15:0]        term_expon;
    logic               last_term;
    logic               status;
  } out_beat_t;

  // one product table entry
  typedef struct packed {
    logic signed [35:0] coef;
    logic [15:0]        expon;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

  // table write data select
  typedef enum logic [1:0] {
    WSEL_NEW  = 2'd0,
    WSEL_MOVE = 2'd1,
    WSEL_ACC  = 2'd2
  } wsel_t;

  // source of a candidate result term
  typedef enum logic [1:0] {
    OFF_PROD   = 2'd0,
    OFF_BOTH   = 2'd1,
    OFF_FIRST  = 2'd2,
    OFF_SECOND = 2'd3
  } offer_sel_t;

  typedef struct packed {
    logic       ld_first;
    logic       ld_second;
    logic       mul_go;
    logic       ram_re;
    logic       ram_we;
    wsel_t      wsel;
    logic       offer;
    offer_sel_t offer_sel;
    logic       finish;
    logic       kind;
    logic       flag;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic rd_gt;
    logic rd_eq;
    logic sum_gt;
    logic sum_eq;
  } dp_stat_t;

endpackage

@@ design/spma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ design/spma_dp.sv @@
// Datapath: term lists, multiplier, product table, saturating adder and result staging.
module spma_dp #(
  parameter int MAX_TERMS     = spma_pkg::MAX_TERMS_DEF,
  parameter int PRODUCT_TERMS = spma_pkg::PRODUCT_TERMS_DEF,
  parameter int IDX_W         = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  parameter int PIDX_W        = (PRODUCT_TERMS > 1) ? $clog2(PRODUCT_TERMS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spma_pkg::dp_cmd_t   cmd,
  input  logic [IDX_W-1:0]    ld_idx,
  input  logic [IDX_W-1:0]    a_idx,
  input  logic [IDX_W-1:0]    b_idx,
  input  logic [PIDX_W-1:0]   ram_raddr,
  input  logic [PIDX_W-1:0]   ram_waddr,
  input  spma_pkg::in_beat_t  in_data,
  output spma_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output spma_pkg::out_beat_t out_data
);
  import spma_pkg::*;

  logic signed [15:0] first_coef_r  [MAX_TERMS];
  logic [14:0]        first_expon_r [MAX_TERMS];
  logic signed [15:0] second_coef_r [MAX_TERMS];
  logic [14:0]        second_expon_r[MAX_TERMS];

  logic signed [15:0] fa_coef, sb_coef;
  logic [14:0]        fa_expon, sb_expon;
  logic signed [31:0] mul_coef_r;
  logic [15:0]        mul_expon_r;
  logic [TBL_W-1:0]   ram_rdata;
  tbl_entry_t         rd, wr;
  logic signed [36:0] acc_sum;
  logic signed [35:0] acc_sat;
  logic signed [16:0] both_sum;
  logic signed [35:0] off_coef;
  logic [15:0]        off_expon;
  logic               take;
  logic [OUT_W-1:0]   taken_r;
  logic               pend_valid_r;
  logic signed [35:0] pend_coef_r;
  logic [15:0]        pend_expon_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  // term list storage
  always_ff @(posedge clk) begin
    if (cmd.ld_first) begin
      first_coef_r[ld_idx]  <= in_data.term_coef_in;
      first_expon_r[ld_idx] <= in_data.term_expon_in;
    end
    if (cmd.ld_second) begin
      second_coef_r[ld_idx]  <= in_data.term_coef_in;
      second_expon_r[ld_idx] <= in_data.term_expon_in;
    end
  end

  assign fa_coef  = first_coef_r[a_idx];
  assign fa_expon = first_expon_r[a_idx];
  assign sb_coef  = second_coef_r[b_idx];
  assign sb_expon = second_expon_r[b_idx];

  // pair product, registered
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mul_coef_r  <= fa_coef * sb_coef;
      mul_expon_r <= {1'b0, fa_expon} + {1'b0, sb_expon};
    end
  end

  // product table
  assign rd = tbl_entry_t'(ram_rdata);

  assign acc_sum = 37'(rd.coef) + 37'(mul_coef_r);
  always_comb begin
    if (acc_sum[36] != acc_sum[35]) begin
      acc_sat = acc_sum[36] ? COEF_MIN : COEF_MAX;
    end else begin
      acc_sat = acc_sum[35:0];
    end
  end

  always_comb begin
    wr = rd;
    case (cmd.wsel)
      WSEL_NEW: begin
        wr.coef  = 36'(mul_coef_r);
        wr.expon = mul_expon_r;
      end
      WSEL_ACC:  wr.coef = acc_sat;
      default:   wr = rd;
    endcase
  end

  spma_ram #(
    .WIDTH (TBL_W),
    .DEPTH (PRODUCT_TERMS),
    .AW    (PIDX_W)
  ) u_tbl (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_waddr),
    .wdata (wr),
    .re    (cmd.ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // candidate term
  assign both_sum = 17'(fa_coef) + 17'(sb_coef);
  always_comb begin
    case (cmd.offer_sel)
      OFF_PROD: begin
        off_coef  = rd.coef;
        off_expon = rd.expon;
      end
      OFF_BOTH: begin
        off_coef  = 36'(both_sum);
        off_expon = {1'b0, fa_expon};
      end
      OFF_FIRST: begin
        off_coef  = 36'(fa_coef);
        off_expon = {1'b0, fa_expon};
      end
      default: begin
        off_coef  = 36'(sb_coef);
        off_expon = {1'b0, sb_expon};
      end
    endcase
  end

  assign take = cmd.offer && (off_coef != '0) && (taken_r < OUT_W'(OUT_LIMIT));

  // one-term lookahead so the final beat can carry last_term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      taken_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        pend_valid_r <= 1'b1;
        pend_coef_r  <= off_coef;
        pend_expon_r <= off_expon;
        taken_r      <= taken_r + OUT_W'(1);
        if (pend_valid_r) begin
          out_valid_r       <= 1'b1;
          out_r.list_kind   <= cmd.kind;
          out_r.term_coef   <= pend_coef_r;
          out_r.term_expon  <= pend_expon_r;
          out_r.last_term   <= 1'b0;
          out_r.status      <= cmd.flag;
        end else if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end else if (cmd.finish) begin
        pend_valid_r     <= 1'b0;
        taken_r          <= '0;
        out_valid_r      <= 1'b1;
        out_r.list_kind  <= cmd.kind;
        out_r.term_coef  <= pend_valid_r ? pend_coef_r : '0;
        out_r.term_expon <= pend_valid_r ? pend_expon_r : '0;
        out_r.last_term  <= 1'b1;
        out_r.status     <= cmd.flag;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.rd_gt    = rd.expon > mul_expon_r;
  assign stat.rd_eq    = rd.expon == mul_expon_r;
  assign stat.sum_gt   = fa_expon > sb_expon;
  assign stat.sum_eq   = fa_expon == sb_expon;

endmodule

@@ design/spma_ctrl.sv @@
// Controller: request decode, list counts, pair walk, table search/shift and emission sequencing.
module spma_ctrl #(
  parameter int MAX_TERMS     = spma_pkg::MAX_TERMS_DEF,
  parameter int PRODUCT_TERMS = spma_pkg::PRODUCT_TERMS_DEF,
  parameter int IDX_W         = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  parameter int PIDX_W        = (PRODUCT_TERMS > 1) ? $clog2(PRODUCT_TERMS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  spma_pkg::dp_stat_t stat,
  output spma_pkg::dp_cmd_t  cmd,
  output logic [IDX_W-1:0]   ld_idx,
  output logic [IDX_W-1:0]   a_idx,
  output logic [IDX_W-1:0]   b_idx,
  output logic [PIDX_W-1:0]  ram_raddr,
  output logic [PIDX_W-1:0]  ram_waddr
);
  import spma_pkg::*;

  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int PCNT_W = $clog2(PRODUCT_TERMS + 1);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_P_MUL     = 10'b00_0000_0010,
    ST_P_SRCH_RD = 10'b00_0000_0100,
    ST_P_SRCH_CM = 10'b00_0000_1000,
    ST_P_SHIFT_R = 10'b00_0001_0000,
    ST_P_SHIFT_W = 10'b00_0010_0000,
    ST_P_EMIT_RD = 10'b00_0100_0000,
    ST_P_EMIT_OF = 10'b00_1000_0000,
    ST_S_STEP    = 10'b01_0000_0000,
    ST_FINISH    = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fcnt_r, fcnt_nxt, scnt_r, scnt_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt, i_r, i_nxt, k_r, k_nxt, km1;
  logic              drop_r, drop_nxt;
  logic              kind_r, kind_nxt;
  logic              accept;
  logic              b_last, a_last, a_more, b_more;
  state_t            pair_done_st;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign km1 = k_r - PCNT_W'(1);

  assign b_last = (b_r + CNT_W'(1)) == scnt_r;
  assign a_last = (a_r + CNT_W'(1)) == fcnt_r;
  assign a_more = a_r < fcnt_r;
  assign b_more = b_r < scnt_r;
  assign pair_done_st = (a_last && b_last) ? ST_P_EMIT_RD : ST_P_MUL;

  assign ld_idx    = (req_type == REQ_LOAD_A) ? fcnt_r[IDX_W-1:0] : scnt_r[IDX_W-1:0];
  assign a_idx     = a_r[IDX_W-1:0];
  assign b_idx     = b_r[IDX_W-1:0];

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    fcnt_nxt  = fcnt_r;
    scnt_nxt  = scnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    pcnt_nxt  = pcnt_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    drop_nxt  = drop_r;
    kind_nxt  = kind_r;
    ram_raddr = i_r[PIDX_W-1:0];
    ram_waddr = i_r[PIDX_W-1:0];
    cmd           = '0;
    cmd.wsel      = WSEL_NEW;
    cmd.offer_sel = OFF_PROD;
    cmd.kind      = kind_r;
    cmd.flag      = drop_r;

    // walk to the next pair, with b inner
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_CLEAR: begin
              fcnt_nxt = '0;
              scnt_nxt = '0;
              pcnt_nxt = '0;
              drop_nxt = 1'b0;
            end
            REQ_LOAD_A: begin
              if (fcnt_r < CNT_W'(MAX_TERMS)) begin
                cmd.ld_first = 1'b1;
                fcnt_nxt     = fcnt_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            REQ_LOAD_B: begin
              if (scnt_r < CNT_W'(MAX_TERMS)) begin
                cmd.ld_second = 1'b1;
                scnt_nxt      = scnt_r + CNT_W'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            REQ_PROD: begin
              kind_nxt = KIND_PROD;
              a_nxt    = '0;
              b_nxt    = '0;
              pcnt_nxt = '0;
              k_nxt    = '0;
              state_nxt = (fcnt_r == '0 || scnt_r == '0) ? ST_P_EMIT_RD : ST_P_MUL;
            end
            REQ_SUM: begin
              kind_nxt  = KIND_SUM;
              a_nxt     = '0;
              b_nxt     = '0;
              state_nxt = ST_S_STEP;
            end
            default: ;
          endcase
        end
      end

      ST_P_MUL: begin
        cmd.mul_go = 1'b1;
        i_nxt      = '0;
        state_nxt  = ST_P_SRCH_RD;
      end

      ST_P_SRCH_RD: begin
        if (i_r < pcnt_r) begin
          cmd.ram_re = 1'b1;
          state_nxt  = ST_P_SRCH_CM;
        end else if (pcnt_r >= PCNT_W'(PRODUCT_TERMS)) begin
          drop_nxt  = 1'b1;
          a_nxt     = b_last ? a_r + CNT_W'(1) : a_r;
          b_nxt     = b_last ? '0 : b_r + CNT_W'(1);
          k_nxt     = '0;
          state_nxt = pair_done_st;
        end else begin
          k_nxt     = pcnt_r;
          state_nxt = ST_P_SHIFT_R;
        end
      end

      ST_P_SRCH_CM: begin
        if (stat.rd_gt) begin
          i_nxt     = i_r + PCNT_W'(1);
          state_nxt = ST_P_SRCH_RD;
        end else if (stat.rd_eq) begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = WSEL_ACC;
          a_nxt      = b_last ? a_r + CNT_W'(1) : a_r;
          b_nxt      = b_last ? '0 : b_r + CNT_W'(1);
          k_nxt      = '0;
          state_nxt  = pair_done_st;
        end else if (pcnt_r >= PCNT_W'(PRODUCT_TERMS)) begin
          drop_nxt  = 1'b1;
          a_nxt     = b_last ? a_r + CNT_W'(1) : a_r;
          b_nxt     = b_last ? '0 : b_r + CNT_W'(1);
          k_nxt     = '0;
          state_nxt = pair_done_st;
        end else begin
          k_nxt     = pcnt_r;
          state_nxt = ST_P_SHIFT_R;
        end
      end

      ST_P_SHIFT_R: begin
        if (k_r > i_r) begin
          cmd.ram_re = 1'b1;
          ram_raddr  = km1[PIDX_W-1:0];
          state_nxt  = ST_P_SHIFT_W;
        end else begin
          cmd.ram_we = 1'b1;
          cmd.wsel   = WSEL_NEW;
          pcnt_nxt   = pcnt_r + PCNT_W'(1);
          a_nxt      = b_last ? a_r + CNT_W'(1) : a_r;
          b_nxt      = b_last ? '0 : b_r + CNT_W'(1);
          k_nxt      = '0;
          state_nxt  = pair_done_st;
        end
      end

      ST_P_SHIFT_W: begin
        cmd.ram_we = 1'b1;
        cmd.wsel   = WSEL_MOVE;
        ram_waddr  = k_r[PIDX_W-1:0];
        k_nxt      = km1;
        state_nxt  = ST_P_SHIFT_R;
      end

      ST_P_EMIT_RD: begin
        if (k_r < pcnt_r) begin
          cmd.ram_re = 1'b1;
          ram_raddr  = k_r[PIDX_W-1:0];
          state_nxt  = ST_P_EMIT_OF;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_P_EMIT_OF: begin
        if (stat.out_free) begin
          cmd.offer     = 1'b1;
          cmd.offer_sel = OFF_PROD;
          k_nxt         = k_r + PCNT_W'(1);
          state_nxt     = ST_P_EMIT_RD;
        end
      end

      ST_S_STEP: begin
        if (!(a_more || b_more)) begin
          state_nxt = ST_FINISH;
        end else if (stat.out_free) begin
          cmd.offer = 1'b1;
          if (a_more && b_more) begin
            if (stat.sum_eq) begin
              cmd.offer_sel = OFF_BOTH;
              a_nxt = a_r + CNT_W'(1);
              b_nxt = b_r + CNT_W'(1);
            end else if (stat.sum_gt) begin
              cmd.offer_sel = OFF_FIRST;
              a_nxt = a_r + CNT_W'(1);
            end else begin
              cmd.offer_sel = OFF_SECOND;
              b_nxt = b_r + CNT_W'(1);
            end
          end else if (a_more) begin
            cmd.offer_sel = OFF_FIRST;
            a_nxt = a_r + CNT_W'(1);
          end else begin
            cmd.offer_sel = OFF_SECOND;
            b_nxt = b_r + CNT_W'(1);
          end
        end
      end

      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fcnt_r  <= '0;
      scnt_r  <= '0;
      a_r     <= '0;
      b_r     <= '0;
      pcnt_r  <= '0;
      i_r     <= '0;
      k_r     <= '0;
      drop_r  <= 1'b0;
      kind_r  <= KIND_PROD;
    end else begin
      state_r <= state_nxt;
      fcnt_r  <= fcnt_nxt;
      scnt_r  <= scnt_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      pcnt_r  <= pcnt_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      drop_r  <= drop_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

@@ design/sparse_poly_mult_add_unit.sv @@
// Top level of the sparse polynomial multiply/add unit.
// Holds two sparse polynomials of up to MAX_TERMS terms each, loaded one term per beat, and
// emits their product or their sum as a stream of nonzero terms in descending exponent order,
// the final beat marked by last_term (an all-zero result is sent as a single 0,0 term). Clear
// and load requests are completed in the idle state. A product request walks the term pairs;
// for each pair the product is added to the table entry of equal exponent if there is one,
// else the lower entries are moved down a slot to open one for it. Every search step reads one
// entry of the product table RAM, and every move reads one entry and writes it back a slot
// lower. The product is then read out one table entry at a time. A sum request takes one merge
// step per cycle while the output register is free, each step taking one term from either
// list or one from both. Either emission ends with a final beat that carries last_term. A new
// request is taken once the previous one has handed its last beat to the output register.
module sparse_poly_mult_add_unit #(
  parameter int MAX_TERMS     = spma_pkg::MAX_TERMS_DEF,
  parameter int PRODUCT_TERMS = spma_pkg::PRODUCT_TERMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spma_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spma_pkg::out_beat_t out_data
);
  import spma_pkg::*;

  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int PIDX_W = (PRODUCT_TERMS > 1) ? $clog2(PRODUCT_TERMS) : 1;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [IDX_W-1:0]  ld_idx, a_idx, b_idx;
  logic [PIDX_W-1:0] ram_raddr, ram_waddr;

  spma_ctrl #(
    .MAX_TERMS     (MAX_TERMS),
    .PRODUCT_TERMS (PRODUCT_TERMS),
    .IDX_W         (IDX_W),
    .PIDX_W        (PIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_data.req_type),
    .stat      (stat),
    .cmd       (cmd),
    .ld_idx    (ld_idx),
    .a_idx     (a_idx),
    .b_idx     (b_idx),
    .ram_raddr (ram_raddr),
    .ram_waddr (ram_waddr)
  );

  spma_dp #(
    .MAX_TERMS     (MAX_TERMS),
    .PRODUCT_TERMS (PRODUCT_TERMS),
    .IDX_W         (IDX_W),
    .PIDX_W        (PIDX_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ld_idx    (ld_idx),
    .a_idx     (a_idx),
    .b_idx     (b_idx),
    .ram_raddr (ram_raddr),
    .ram_waddr (ram_waddr),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/sparse_poly_mult_add_unit_tb.sv @@
// Self-checking testbench for the sparse polynomial multiply/add unit.
`timescale 1ns / 1ps

module sparse_poly_mult_add_unit_tb;
  import spma_pkg::*;

  localparam int NTERMS     = 8;
  localparam int NTABLE     = 64;
  localparam int CYCLE_CAP  = 3000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  sparse_poly_mult_add_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic signed [15:0] a_coef [NTERMS];
  logic [14:0]        a_exp  [NTERMS];
  logic signed [15:0] b_coef [NTERMS];
  logic [14:0]        b_exp  [NTERMS];
  int                 a_cnt, b_cnt, tbl_cnt;
  logic signed [35:0] tbl_coef [NTABLE];
  logic [15:0]        tbl_exp  [NTABLE];
  logic               drop_flag;

  out_beat_t expected_terms[$];
  int        pushed;
  int        mismatches;
  int        cycles;
  bit        quiet_tail;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic logic signed [35:0] clamp36(longint v);
    if (v > longint'(COEF_MAX)) return COEF_MAX;
    if (v < longint'(COEF_MIN)) return COEF_MIN;
    return v[35:0];
  endfunction

  // queue one emitted term, zero coefficients skipped, capped at the output limit
  function automatic void push_term(logic kind, longint c, logic [15:0] e, ref int n);
    out_beat_t t;
    if (c == 0 || n >= OUT_LIMIT) return;
    t.list_kind  = kind;
    t.term_coef  = c[35:0];
    t.term_expon = e;
    t.last_term  = 1'b0;
    t.status     = drop_flag;
    expected_terms.push_back(t);
    pushed++;
    n++;
  endfunction

  function automatic void close_list(logic kind, int n);
    out_beat_t t;
    if (n == 0) begin
      t = '0;
      t.list_kind = kind;
      t.last_term = 1'b1;
      t.status    = drop_flag;
      expected_terms.push_back(t);
      pushed++;
    end else begin
      t = expected_terms.pop_back();
      t.last_term = 1'b1;
      expected_terms.push_back(t);
    end
  endfunction

  function automatic void merge_product(longint c, logic [15:0] e);
    int i;
    i = 0;
    while (i < tbl_cnt && tbl_exp[i] > e) i++;
    if (i < tbl_cnt && tbl_exp[i] == e) begin
      tbl_coef[i] = clamp36(longint'(tbl_coef[i]) + c);
      return;
    end
    if (tbl_cnt >= NTABLE) begin
      drop_flag = 1'b1;
      return;
    end
    for (int k = tbl_cnt; k > i; k--) begin
      tbl_coef[k] = tbl_coef[k-1];
      tbl_exp[k]  = tbl_exp[k-1];
    end
    tbl_coef[i] = c[35:0];
    tbl_exp[i]  = e;
    tbl_cnt++;
  endfunction

  // advance the predictor by one accepted request beat
  function automatic void predict_request(in_beat_t b);
    int n, i, j;
    n = 0;
    case (b.req_type)
      REQ_CLEAR: begin
        a_cnt = 0; b_cnt = 0; tbl_cnt = 0; drop_flag = 1'b0;
      end
      REQ_LOAD_A: begin
        if (a_cnt < NTERMS) begin
          a_coef[a_cnt] = b.term_coef_in; a_exp[a_cnt] = b.term_expon_in; a_cnt++;
        end else drop_flag = 1'b1;
      end
      REQ_LOAD_B: begin
        if (b_cnt < NTERMS) begin
          b_coef[b_cnt] = b.term_coef_in; b_exp[b_cnt] = b.term_expon_in; b_cnt++;
        end else drop_flag = 1'b1;
      end
      REQ_PROD: begin
        tbl_cnt = 0;
        for (i = 0; i < a_cnt; i++)
          for (j = 0; j < b_cnt; j++)
            merge_product(longint'(a_coef[i]) * longint'(b_coef[j]),
                          {1'b0, a_exp[i]} + {1'b0, b_exp[j]});
        for (i = 0; i < tbl_cnt; i++) push_term(KIND_PROD, tbl_coef[i], tbl_exp[i], n);
        close_list(KIND_PROD, n);
      end
      REQ_SUM: begin
        i = 0; j = 0;
        while (i < a_cnt && j < b_cnt) begin
          if (a_exp[i] == b_exp[j]) begin
            push_term(KIND_SUM, longint'(a_coef[i]) + longint'(b_coef[j]), a_exp[i], n);
            i++; j++;
          end else if (a_exp[i] > b_exp[j]) begin
            push_term(KIND_SUM, a_coef[i], a_exp[i], n); i++;
          end else begin
            push_term(KIND_SUM, b_coef[j], b_exp[j], n); j++;
          end
        end
        for (; i < a_cnt; i++) push_term(KIND_SUM, a_coef[i], a_exp[i], n);
        for (; j < b_cnt; j++) push_term(KIND_SUM, b_coef[j], b_exp[j], n);
        close_list(KIND_SUM, n);
      end
      default: ;
    endcase
  endfunction

  // result side: random stalls, compare each beat with the oldest expectation
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_terms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_data);
        end else begin
          out_beat_t want;
          want = expected_terms.pop_front();
          if (want !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
  end

  // send one request beat; optional idle gap first, valid stays up into the next beat
  task automatic send_request(in_beat_t b);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(b);
  endtask

  function automatic in_beat_t make_req(logic [2:0] r, logic [15:0] c, logic [14:0] e);
    in_beat_t b;
    b.req_type = r; b.term_coef_in = c; b.term_expon_in = e;
    return b;
  endfunction

  // directed rows: request, coefficient, exponent, and an optional typed answer
  typedef struct {
    logic [2:0]  req;
    logic [15:0] coef;
    logic [14:0] expon;
    bit          has_want;
    out_beat_t   want;
  } dir_row_t;

  dir_row_t rows[$];

  function automatic dir_row_t row(logic [2:0] r, logic [15:0] c, logic [14:0] e);
    dir_row_t d;
    d.req = r; d.coef = c; d.expon = e; d.has_want = 0; d.want = '0;
    return d;
  endfunction

  function automatic dir_row_t row_want(logic [2:0] r, out_beat_t w);
    dir_row_t d;
    d = row(r, '0, '0);
    d.has_want = 1; d.want = w;
    return d;
  endfunction

  // random well-formed polynomial, descending exponents, sometimes out of order
  task automatic load_poly(logic [2:0] which, int nterms, bit messy);
    logic [14:0] e;
    logic [15:0] c;
    e = 15'($urandom_range(0, 32767));
    for (int k = 0; k < nterms; k++) begin
      c = 16'($urandom);
      if ($urandom_range(0, 7) == 0) c = 16'h0000;
      send_request(make_req(which, c, e));
      if (messy && $urandom_range(0, 2) == 0) e = 15'($urandom);
      else if (e > 0) e = e - 15'($urandom_range(1, (e < 2000) ? e : 2000));
    end
  endtask

  initial begin
    out_beat_t w;
    int pick, na, nb, pushed_before;
    cycles = 0; mismatches = 0; quiet_tail = 0; stim_done = 0; pushed = 0;
    a_cnt = 0; b_cnt = 0; tbl_cnt = 0; drop_flag = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty lists after reset give the lone zero term
    w = '0; w.list_kind = KIND_PROD; w.last_term = 1'b1;
    rows.push_back(row_want(REQ_PROD, w));
    w.list_kind = KIND_SUM;
    rows.push_back(row_want(REQ_SUM, w));
    // coefficient and exponent extremes, product of two most negative values
    rows.push_back(row(REQ_LOAD_A, 16'h8000, 15'h7fff));
    rows.push_back(row(REQ_LOAD_A, 16'h7fff, 15'h0000));
    rows.push_back(row(REQ_LOAD_B, 16'h8000, 15'h7fff));
    rows.push_back(row(REQ_LOAD_B, 16'h8001, 15'h0000));
    rows.push_back(row(REQ_PROD, 0, 0));
    rows.push_back(row(REQ_SUM, 0, 0));
    // unused request codes are ignored
    rows.push_back(row(3'd5, 16'hffff, 15'h7fff));
    rows.push_back(row(3'd7, 16'h5555, 15'h2aaa));
    // cancelling terms: sum collapses to the zero term
    rows.push_back(row(REQ_CLEAR, 0, 0));
    rows.push_back(row(REQ_LOAD_A, 16'd5, 15'd3));
    rows.push_back(row(REQ_LOAD_B, -16'sd5, 15'd3));
    w = '0; w.list_kind = KIND_SUM; w.last_term = 1'b1;
    rows.push_back(row_want(REQ_SUM, w));
    rows.push_back(row(REQ_PROD, 0, 0));
    // overfill the first list, flag sticks
    for (int k = 0; k < 8; k++) rows.push_back(row(REQ_LOAD_A, 16'(k + 1), 15'(k)));
    rows.push_back(row(REQ_SUM, 0, 0));
    rows.push_back(row(REQ_CLEAR, 0, 0));

    // a typed answer must be the single beat queued by its own request
    foreach (rows[i]) begin
      pushed_before = pushed;
      send_request(make_req(rows[i].req, rows[i].coef, rows[i].expon));
      if (rows[i].has_want && (pushed - pushed_before != 1 ||
                               expected_terms[$] !== rows[i].want)) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d prediction disagrees with table", i);
      end
    end

    // random part: mostly well-formed load, load, emit sequences
    for (int s = 0; s < 7; s++) begin
      if (s == 5) quiet_tail = 1;
      pick = $urandom_range(0, 9);
      send_request(make_req(REQ_CLEAR, 16'($urandom), 15'($urandom)));
      na = $urandom_range(0, (pick == 0) ? 10 : 8);
      nb = $urandom_range(0, (pick == 1) ? 10 : 8);
      load_poly(REQ_LOAD_A, na, pick == 2);
      load_poly(REQ_LOAD_B, nb, pick == 3);
      if (pick == 4) send_request(make_req(3'($urandom_range(5, 7)), 16'($urandom),
                                           15'($urandom)));
      send_request(make_req($urandom_range(0, 1) ? REQ_PROD : REQ_SUM, 16'($urandom),
                            15'($urandom)));
      send_request(make_req($urandom_range(0, 1) ? REQ_PROD : REQ_SUM, 16'($urandom),
                            15'($urandom)));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // end of run: drain, settle, report
  initial begin
    @(posedge clk iff stim_done);
    while (expected_terms.size() != 0 && cycles < CYCLE_CAP) @(posedge clk);
    repeat (200) @(posedge clk);
    if (cycles >= CYCLE_CAP) begin
      $display("CHECKS FAILED");
    end else if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    @(posedge clk iff cycles >= CYCLE_CAP + 1000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
